@@ design/mmlns_pkg.sv @@
`timescale 1ns / 1ps

package mmlns_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int HOLD_W  = 10;
    localparam int FNUM_W  = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [HOLD_W-1:0] GAP_HOLD_RST  = 10'd20;
    localparam logic [HOLD_W-1:0] NOTE_HOLD_RST = 10'd200;
    localparam logic [HOLD_W-1:0] REST_HOLD_RST = 10'd200;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_HOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_HOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_HOLD = 2'd2;

    localparam logic [1:0] CMD_KEY_OFF = 2'd0;
    localparam logic [1:0] CMD_NOTE_ON = 2'd1;
    localparam logic [1:0] CMD_REST    = 2'd2;

    typedef enum logic [1:0] {
        TAIL_NONE = 2'd0,
        TAIL_END  = 2'd1,
        TAIL_REST = 2'd2
    } tail_t;

    // One queued unit of work: optional note (key-off + note-on), then optional tail
    typedef struct packed {
        logic       has_note;
        logic [2:0] blk;
        logic [3:0] key;
        tail_t      tail;
    } action_t;

    typedef struct packed {
        logic [HOLD_W-1:0] gap;
        logic [HOLD_W-1:0] note;
        logic [HOLD_W-1:0] rest;
    } hold_cfg_t;

    function automatic logic [FNUM_W-1:0] fnum_lookup(input logic [3:0] key);
        logic [FNUM_W-1:0] f;
        unique case (key)
            4'd0:    f = 11'd617;
            4'd1:    f = 11'd653;
            4'd2:    f = 11'd692;
            4'd3:    f = 11'd733;
            4'd4:    f = 11'd777;
            4'd5:    f = 11'd823;
            4'd6:    f = 11'd872;
            4'd7:    f = 11'd924;
            4'd8:    f = 11'd979;
            4'd9:    f = 11'd1038;
            4'd10:   f = 11'd1100;
            4'd11:   f = 11'd1165;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

@@ design/mmlns_front.sv @@
`timescale 1ns / 1ps

module mmlns_front
    import mmlns_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] symbol,
    input  logic       q_full,
    output logic       q_push,
    output action_t    q_data
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UG    = 8'h47;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LG    = 8'h67;
    localparam logic [7:0] CH_UO    = 8'h4F;
    localparam logic [7:0] CH_LO    = 8'h6F;
    localparam logic [7:0] CH_UR    = 8'h52;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [3:0] OCT_RST  = 4'd4;

    function automatic logic [3:0] letter_semi(input logic [2:0] idx);
        logic [3:0] s;
        unique case (idx)
            3'd0:    s = 4'd9;
            3'd1:    s = 4'd11;
            3'd2:    s = 4'd0;
            3'd3:    s = 4'd2;
            3'd4:    s = 4'd4;
            3'd5:    s = 4'd5;
            3'd6:    s = 4'd7;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    logic [3:0] octave_reg, octave_next;
    logic       held_valid_reg, held_valid_next;
    logic [3:0] held_semi_reg, held_semi_next;
    logic       await_reg, await_next;

    logic       accept;
    logic       sharp;
    logic [7:0] ucase_off;
    logic [7:0] lcase_off;
    logic [7:0] digit_off;
    logic [3:0] semi;
    logic       wrap;
    logic [3:0] blk_raw;
    action_t    act;

    assign in_stall  = q_full;
    assign accept    = in_valid && !in_stall;
    assign sharp     = (symbol == CH_PLUS) || (symbol == CH_HASH);
    assign ucase_off = symbol - CH_UA;
    assign lcase_off = symbol - CH_LA;
    assign digit_off = symbol - CH_ZERO;

    // Sharp on B lands on 12: next octave, key C
    assign semi    = held_semi_reg + {3'd0, sharp};
    assign wrap    = (semi == 4'd12);
    assign blk_raw = octave_reg + {3'd0, wrap};

    always_comb
    begin
        octave_next     = octave_reg;
        held_valid_next = held_valid_reg;
        held_semi_next  = held_semi_reg;
        await_next      = 1'b0;
        act.has_note    = 1'b0;
        act.blk         = (blk_raw > 4'd7) ? 3'd7 : blk_raw[2:0];
        act.key         = wrap ? 4'd0 : semi;
        act.tail        = TAIL_NONE;

        if (await_reg && symbol >= CH_ONE && symbol <= CH_EIGHT) begin
            octave_next = digit_off[3:0];
        end else begin
            if (held_valid_reg) begin
                act.has_note    = 1'b1;
                held_valid_next = 1'b0;
            end
            if (!(held_valid_reg && sharp)) begin
                unique if (symbol == CH_NUL) begin
                    act.tail        = TAIL_END;
                    octave_next     = OCT_RST;
                    held_valid_next = 1'b0;
                    held_semi_next  = 4'd0;
                end else if (symbol == CH_UO || symbol == CH_LO) begin
                    await_next = 1'b1;
                end else if (symbol >= CH_UA && symbol <= CH_UG) begin
                    held_valid_next = 1'b1;
                    held_semi_next  = letter_semi(ucase_off[2:0]);
                end else if (symbol >= CH_LA && symbol <= CH_LG) begin
                    held_valid_next = 1'b1;
                    held_semi_next  = letter_semi(lcase_off[2:0]);
                end else if (symbol == CH_UR || symbol == CH_LR) begin
                    act.tail = TAIL_REST;
                end else begin
                    act.tail = TAIL_NONE;
                end
            end
        end
    end

    assign q_push = accept && (act.has_note || act.tail != TAIL_NONE);
    assign q_data = act;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            octave_reg     <= OCT_RST;
            held_valid_reg <= 1'b0;
            held_semi_reg  <= 4'd0;
            await_reg      <= 1'b0;
        end else if (accept) begin
            octave_reg     <= octave_next;
            held_valid_reg <= held_valid_next;
            held_semi_reg  <= held_semi_next;
            await_reg      <= await_next;
        end
    end

endmodule

@@ design/mmlns_queue.sv @@
`timescale 1ns / 1ps

module mmlns_queue
    import mmlns_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  action_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    head_valid,
    output action_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    action_t         entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/mmlns_back.sv @@
`timescale 1ns / 1ps

module mmlns_back
    import mmlns_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  hold_cfg_t         hold_cfg,
    input  logic              head_valid,
    input  action_t           head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        command,
    output logic [2:0]        octave_block,
    output logic [FNUM_W-1:0] freq_number,
    output logic [HOLD_W-1:0] hold_ms,
    output logic              last
);

    typedef enum logic [2:0] {
        PH_KEY_OFF = 3'b001,
        PH_NOTE_ON = 3'b010,
        PH_TAIL    = 3'b100
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [2:0]        blk_reg, blk_next;
    logic [FNUM_W-1:0] fnum_reg, fnum_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic              last_reg, last_next;
    logic              load;
    logic              emit_tail;

    assign load = head_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = CMD_KEY_OFF;
        blk_next   = 3'd0;
        fnum_next  = '0;
        hold_next  = hold_cfg.gap;
        last_next  = 1'b0;
        emit_tail  = 1'b0;

        unique case (phase_reg)
            PH_KEY_OFF: begin
                if (head.has_note) begin
                    phase_next = PH_NOTE_ON;
                end else begin
                    emit_tail = 1'b1;
                end
            end
            PH_NOTE_ON: begin
                cmd_next  = CMD_NOTE_ON;
                blk_next  = head.blk;
                fnum_next = fnum_lookup(head.key);
                hold_next = hold_cfg.note;
                if (head.tail == TAIL_NONE) begin
                    last_next  = 1'b1;
                    phase_next = PH_KEY_OFF;
                end else begin
                    phase_next = PH_TAIL;
                end
            end
            PH_TAIL: begin
                emit_tail = 1'b1;
            end
            default: begin
                phase_next = PH_KEY_OFF;
            end
        endcase

        if (emit_tail) begin
            last_next  = 1'b1;
            phase_next = PH_KEY_OFF;
            if (head.tail == TAIL_REST) begin
                cmd_next  = CMD_REST;
                hold_next = hold_cfg.rest;
            end else begin
                // end of string: final key-off with no wait
                cmd_next  = CMD_KEY_OFF;
                hold_next = '0;
            end
        end

        if (load) begin
            out_valid_next = 1'b1;
        end else begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    assign pop = load && last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_KEY_OFF;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (load) begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            cmd_reg  <= cmd_next;
            blk_reg  <= blk_next;
            fnum_reg <= fnum_next;
            hold_reg <= hold_next;
            last_reg <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign command      = cmd_reg;
    assign octave_block = blk_reg;
    assign freq_number  = fnum_reg;
    assign hold_ms      = hold_reg;
    assign last         = last_reg;

endmodule

@@ design/mml_note_sequencer_top.sv @@
`timescale 1ns / 1ps
// MML note sequencer.
// Input channel: one text byte per item on symbol (in_valid / in_stall); byte 0
// ends the string. Letters A-G are held one byte to catch a sharp, O plus a digit
// 1-8 sets the octave, R gives a rest, other bytes produce nothing.
// Output channel (out_valid / out_stall): command, octave_block, freq_number,
// hold_ms and last; last marks the final result caused by one input byte.
// A byte yields zero to three results: key-off + note-on, then rest or final key-off.
// Config: cfg_we writes cfg_data into gap/note/rest hold registers (index 0..2);
// write only while the block is idle.
// Each action is registered in the queue, then in the back-end output register.
// Throughput: one result per cycle out of the back end while out_stall is low; a
// byte with several results is sent out one result at a time there.
// The front end keeps taking bytes while the action queue has room; in_stall
// rises only when the queue (QUEUE_DEPTH entries) is full.
// When out_stall is high the current result holds, the back end waits and the
// queue fills. Reset clears the octave to 4, drops any held note and empties
// the queue; hold registers return to 20 / 200 / 200 ms.

module mml_note_sequencer_top
    import mmlns_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           symbol,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           command,
    output logic [2:0]           octave_block,
    output logic [FNUM_W-1:0]    freq_number,
    output logic [HOLD_W-1:0]    hold_ms,
    output logic                 last,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HOLD_W-1:0]    cfg_data
);

    hold_cfg_t hold_cfg_reg;
    logic      q_full;
    logic      q_push;
    action_t   q_data;
    logic      q_pop;
    logic      q_head_valid;
    action_t   q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_cfg_reg.gap  <= GAP_HOLD_RST;
            hold_cfg_reg.note <= NOTE_HOLD_RST;
            hold_cfg_reg.rest <= REST_HOLD_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GAP_HOLD:  hold_cfg_reg.gap  <= cfg_data;
                CFG_NOTE_HOLD: hold_cfg_reg.note <= cfg_data;
                CFG_REST_HOLD: hold_cfg_reg.rest <= cfg_data;
                default:       ;
            endcase
        end
    end

    mmlns_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .symbol   (symbol),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    mmlns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    mmlns_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .hold_cfg     (hold_cfg_reg),
        .head_valid   (q_head_valid),
        .head         (q_head),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .command      (command),
        .octave_block (octave_block),
        .freq_number  (freq_number),
        .hold_ms      (hold_ms),
        .last         (last)
    );

endmodule

@@ design/mmlns_checker.sv @@
`timescale 1ns / 1ps

module mmlns_checker
    import mmlns_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [1:0]        command,
    input logic [2:0]        octave_block,
    input logic [FNUM_W-1:0] freq_number,
    input logic [HOLD_W-1:0] hold_ms,
    input logic              last
);

    // stalled result must hold
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(command) && $stable(hold_ms)
            && $stable(freq_number) && $stable(octave_block) && $stable(last))
        else $error("stalled result changed");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command != CMD_NOTE_ON |-> octave_block == 3'd0 && freq_number == '0)
        else $error("block or F-number set on non note-on command");

    a_fnum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command == CMD_NOTE_ON |-> freq_number >= 11'd617 && freq_number <= 11'd1165)
        else $error("note-on F-number out of table range");

    a_rest_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command == CMD_REST |-> last)
        else $error("rest not marked last");

endmodule

bind mml_note_sequencer_top mmlns_checker u_checker (.*);
